### rtl/framebuffer_alpha_blend_store_unit_defines.svh
// ----------------------------------------------------------------------------
// Framebuffer alpha blend store: assertion macros
// Shared concurrent assertion forms for the framebuffer blend store unit.
// ----------------------------------------------------------------------------
`ifndef FRAMEBUFFER_ALPHA_BLEND_STORE_UNIT_DEFINES_SVH
`define FRAMEBUFFER_ALPHA_BLEND_STORE_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define FBAB_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);
`define FBAB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);
`else
`define FBAB_ASSERT_SAME(lbl, ante, cons, msg)
`define FBAB_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### rtl/fbab_pkg.sv
// ----------------------------------------------------------------------------
// Framebuffer alpha blend store package
// Shared widths, operation codes, register indexes and types.
// ----------------------------------------------------------------------------
package fbab_pkg;

    localparam int COORD_W     = 12;
    localparam int DIM_W       = 13;
    localparam int CFG_W       = 9;
    localparam int CFG_IDX_W   = 1;
    localparam int COLOR_W     = 32;
    localparam int CH_W        = 8;
    localparam int MIX_W       = 16;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_BLEND = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] DIM_RESET    = 9'd256;
    localparam logic [CH_W-1:0]  CH_MAX       = 8'd255;
    localparam logic [CH_W-1:0]  ALPHA_OPAQUE = 8'hFF;

    typedef struct packed {
        logic [1:0]         op;
        logic               in_frame;
        logic [COLOR_W-1:0] color;
    } fbab_cmd_t;

    typedef struct packed {
        logic ram_we;
        logic out_load;
    } fbab_back_stat_t;

endpackage

### rtl/fbab_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module fbab_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  logic                                       aclk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/fbab_front.sv
// ----------------------------------------------------------------------------
// Framebuffer front end
// Holds the frame shape, clips each request and forms its linear address.
// ----------------------------------------------------------------------------
module fbab_front import fbab_pkg::*; #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int ADDR_W     = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic [1:0]           s_op,
    input  logic [COORD_W-1:0]   s_pixel_x,
    input  logic [COORD_W-1:0]   s_pixel_y,
    input  logic [COLOR_W-1:0]   s_pixel_color,
    output fbab_cmd_t            cmd,
    output logic [ADDR_W-1:0]    addr
);

    localparam int LIN_W = COORD_W + DIM_W;
    localparam logic [DIM_W-1:0] MAX_W_C = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] MAX_H_C = DIM_W'(MAX_HEIGHT);

    logic [CFG_W-1:0] frame_width_reg, frame_width_next;
    logic [CFG_W-1:0] frame_height_reg, frame_height_next;
    logic [DIM_W-1:0] width_eff, height_eff;
    logic [LIN_W-1:0] lin_addr;

    always_comb begin
        frame_width_next  = frame_width_reg;
        frame_height_next = frame_height_reg;
        if (cfg_we) begin
            case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_next  = cfg_wdata;
                REG_FRAME_HEIGHT: frame_height_next = cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= DIM_RESET;
            frame_height_reg <= DIM_RESET;
        end else begin
            frame_width_reg  <= frame_width_next;
            frame_height_reg <= frame_height_next;
        end
    end

    always_comb begin
        width_eff  = (DIM_W'(frame_width_reg) > MAX_W_C) ? MAX_W_C : DIM_W'(frame_width_reg);
        height_eff = (DIM_W'(frame_height_reg) > MAX_H_C) ? MAX_H_C : DIM_W'(frame_height_reg);
        lin_addr   = LIN_W'(s_pixel_y) * LIN_W'(width_eff) + LIN_W'(s_pixel_x);
        cmd.op     = s_op;
        cmd.in_frame = (DIM_W'(s_pixel_x) < width_eff) && (DIM_W'(s_pixel_y) < height_eff);
        cmd.color  = s_pixel_color;
        addr       = lin_addr[ADDR_W-1:0];
    end

endmodule

### rtl/fbab_queue.sv
// ----------------------------------------------------------------------------
// Framebuffer request queue
// Short FIFO that decouples the front end from the execution back end.
// ----------------------------------------------------------------------------
module fbab_queue import fbab_pkg::*; #(
    parameter int ADDR_W = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  fbab_cmd_t         push_cmd,
    input  logic [ADDR_W-1:0] push_addr,
    input  logic              pop,
    output fbab_cmd_t         head_cmd,
    output logic [ADDR_W-1:0] head_addr,
    output logic              full,
    output logic              empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_C  = PTR_W'(QUEUE_DEPTH - 1);

    fbab_cmd_t         cmd_reg [QUEUE_DEPTH];
    logic [ADDR_W-1:0] addr_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full      = (count_reg == DEPTH_C);
    assign empty     = (count_reg == '0);
    assign head_cmd  = cmd_reg[rd_ptr_reg];
    assign head_addr = addr_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_C) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_C) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            cmd_reg[wr_ptr_reg]  <= push_cmd;
            addr_reg[wr_ptr_reg] <= push_addr;
        end
    end

endmodule

### rtl/fbab_back.sv
// ----------------------------------------------------------------------------
// Framebuffer back end
// Executes writes, reads and blends against the pixel RAM and holds the
// result register.
// ----------------------------------------------------------------------------
module fbab_back import fbab_pkg::*; #(
    parameter int DEPTH  = 65536,
    parameter int ADDR_W = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_empty,
    input  fbab_cmd_t          q_cmd,
    input  logic [ADDR_W-1:0]  q_addr,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [COLOR_W-1:0] m_read_color,
    output logic               m_in_bounds,
    output fbab_back_stat_t    stat
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_MIX  = 2'd2;

    logic [1:0]         state_reg, state_next;
    fbab_cmd_t          cmd_reg, cmd_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic [MIX_W-1:0]   mix_reg [3];
    logic [MIX_W-1:0]   mix_next [3];
    logic               m_valid_reg, m_valid_next;
    logic [COLOR_W-1:0] read_color_reg, read_color_next;
    logic               in_bounds_reg, in_bounds_next;

    logic               out_free;
    logic               out_load;
    logic               ram_we, ram_re;
    logic [ADDR_W-1:0]  ram_raddr, ram_waddr;
    logic [COLOR_W-1:0] ram_wdata, ram_rdata, blended;
    logic [CH_W-1:0]    alpha, alpha_inv;
    logic [MIX_W:0]     quot [3];

    fbab_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_free  = !m_valid_reg || m_ready;
    assign alpha     = cmd_reg.color[COLOR_W-1 -: CH_W];
    assign alpha_inv = CH_MAX - alpha;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            quot[i] = (MIX_W+1)'(mix_reg[i]) + (MIX_W+1)'(mix_reg[i][MIX_W-1:CH_W])
                      + (MIX_W+1)'(1);
            blended[CH_W*i +: CH_W] = quot[i][MIX_W-1:CH_W];
        end
        blended[COLOR_W-1 -: CH_W] = ALPHA_OPAQUE;
    end

    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        addr_next       = addr_reg;
        mix_next        = mix_reg;
        q_pop           = 1'b0;
        out_load        = 1'b0;
        read_color_next = read_color_reg;
        in_bounds_next  = in_bounds_reg;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        ram_raddr       = q_addr;
        ram_waddr       = q_addr;
        ram_wdata       = q_cmd.color;
        case (state_reg)
            S_IDLE: begin
                if (!q_empty && out_free) begin
                    q_pop     = 1'b1;
                    cmd_next  = q_cmd;
                    addr_next = q_addr;
                    if (q_cmd.in_frame && (q_cmd.op == OP_READ || q_cmd.op == OP_BLEND)) begin
                        ram_re     = 1'b1;
                        state_next = S_READ;
                    end else begin
                        out_load        = 1'b1;
                        read_color_next = '0;
                        in_bounds_next  = q_cmd.in_frame;
                        if (q_cmd.in_frame && q_cmd.op == OP_WRITE) begin
                            ram_we = 1'b1;
                        end
                    end
                end
            end
            S_READ: begin
                if (cmd_reg.op == OP_BLEND) begin
                    for (int i = 0; i < 3; i++) begin
                        mix_next[i] = {8'd0, cmd_reg.color[CH_W*i +: CH_W]} * {8'd0, alpha}
                                    + {8'd0, ram_rdata[CH_W*i +: CH_W]} * {8'd0, alpha_inv};
                    end
                    state_next = S_MIX;
                end else if (out_free) begin
                    out_load        = 1'b1;
                    read_color_next = ram_rdata;
                    in_bounds_next  = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_MIX: begin
                if (out_free) begin
                    ram_we          = 1'b1;
                    ram_waddr       = addr_reg;
                    ram_wdata       = blended;
                    out_load        = 1'b1;
                    read_color_next = '0;
                    in_bounds_next  = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
        m_valid_next = out_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        addr_reg       <= addr_next;
        mix_reg        <= mix_next;
        read_color_reg <= read_color_next;
        in_bounds_reg  <= in_bounds_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_read_color  = read_color_reg;
    assign m_in_bounds   = in_bounds_reg;
    assign stat.ram_we   = ram_we;
    assign stat.out_load = out_load;

endmodule

### rtl/framebuffer_alpha_blend_store_unit.sv
// ----------------------------------------------------------------------------
// Framebuffer alpha blend store unit
// ARGB8888 framebuffer with clipped write, read and source-over blend
// requests.
//
//   Channel   Direction  Handshake            Payload
//   s_        in         s_valid / s_ready    op, pixel_x, pixel_y, pixel_color
//   m_        out        m_valid / m_ready    read_color, in_bounds
//   cfg_      in         cfg_we               cfg_index, cfg_wdata
//
// A request enters a two-entry queue in the cycle it is accepted and is
// executed once the back end pops it. A write, a clipped request or an
// unused op completes when popped; a read passes the registered pixel RAM
// read, and a blend that read and the registered mix stage. Reset clears
// the control state only; pixel contents are undefined until written. A
// stalled result holds the back end, and a full queue stalls s_.
// ----------------------------------------------------------------------------
`include "framebuffer_alpha_blend_store_unit_defines.svh"

module framebuffer_alpha_blend_store_unit import fbab_pkg::*; #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_op,
    input  logic [COORD_W-1:0]   s_pixel_x,
    input  logic [COORD_W-1:0]   s_pixel_y,
    input  logic [COLOR_W-1:0]   s_pixel_color,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [COLOR_W-1:0]   m_read_color,
    output logic                 m_in_bounds
);

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    fbab_cmd_t         front_cmd, head_cmd;
    logic [ADDR_W-1:0] front_addr, head_addr;
    logic              q_push, q_pop, q_full, q_empty;
    fbab_back_stat_t   back_stat;

    assign s_ready = !q_full;
    assign q_push  = s_valid && s_ready;

    fbab_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .ADDR_W     (ADDR_W)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_op          (s_op),
        .s_pixel_x     (s_pixel_x),
        .s_pixel_y     (s_pixel_y),
        .s_pixel_color (s_pixel_color),
        .cmd           (front_cmd),
        .addr          (front_addr)
    );

    fbab_queue #(
        .ADDR_W (ADDR_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_cmd  (front_cmd),
        .push_addr (front_addr),
        .pop       (q_pop),
        .head_cmd  (head_cmd),
        .head_addr (head_addr),
        .full      (q_full),
        .empty     (q_empty)
    );

    fbab_back #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_empty      (q_empty),
        .q_cmd        (head_cmd),
        .q_addr       (head_addr),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_color (m_read_color),
        .m_in_bounds  (m_in_bounds),
        .stat         (back_stat)
    );

    `FBAB_ASSERT_SAME(a_color_needs_bounds, m_valid && (m_read_color != '0), m_in_bounds, "nonzero read color on a clipped request")
    `FBAB_ASSERT_SAME(a_no_pop_when_empty, q_empty, !q_pop, "queue popped while empty")
    `FBAB_ASSERT_SAME(a_write_with_result, back_stat.ram_we, back_stat.out_load, "pixel write without its result")
    `FBAB_ASSERT_NEXT(a_result_loaded, back_stat.out_load, m_valid, "loaded result not presented")

endmodule

### tb/framebuffer_alpha_blend_store_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Framebuffer alpha blend store unit testbench
// Drives write, read, blend and unused requests through the s_ channel while
// the frame shape is changed between phases, and checks every m_ result
// against a shadow framebuffer kept in the testbench. Covers clipping, width
// and height at zero and above the maximum, reshaping of stored words,
// back-to-back blends of one pixel, and a long result stall.
// ----------------------------------------------------------------------------
module framebuffer_alpha_blend_store_unit_test;
    import fbab_pkg::*;

    localparam int          MAX_W        = 256;
    localparam int          MAX_H        = 256;
    localparam int          STORE_WORDS  = MAX_W * MAX_H;
    localparam int          DRAIN_CYCLES = 8;
    localparam logic [1:0]  OP_UNUSED    = 2'd3;
    localparam longint      RUN_LIMIT_NS = 4_000_000;

    typedef struct {
        logic [COLOR_W-1:0] read_color;
        logic               in_bounds;
    } pixel_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;
    logic                 s_valid;
    logic                 s_ready;
    logic [1:0]           s_op;
    logic [COORD_W-1:0]   s_pixel_x;
    logic [COORD_W-1:0]   s_pixel_y;
    logic [COLOR_W-1:0]   s_pixel_color;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [COLOR_W-1:0]   m_read_color;
    logic                 m_in_bounds;

    logic [COLOR_W-1:0] shadow_pixels [0:STORE_WORDS-1];
    bit                 shadow_written [0:STORE_WORDS-1];
    logic [CFG_W-1:0]   frame_width_q;
    logic [CFG_W-1:0]   frame_height_q;
    pixel_result_t      pending_pixel_results [$];
    pixel_result_t      oldest_result;

    int                 error_count = 0;
    int                 sender_idle_pct = 0;
    int                 receiver_idle_pct = 0;
    int                 hold_off_len = 0;
    int                 hold_off_serial = 0;
    int                 hold_off_taken = 0;
    int                 hold_off_left = 0;
    logic [COORD_W-1:0] last_x = '0;
    logic [COORD_W-1:0] last_y = '0;

    framebuffer_alpha_blend_store_unit #(
        .MAX_WIDTH (MAX_W),
        .MAX_HEIGHT(MAX_H)
    ) DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_pixel_x    (s_pixel_x),
        .s_pixel_y    (s_pixel_y),
        .s_pixel_color(s_pixel_color),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_color (m_read_color),
        .m_in_bounds  (m_in_bounds)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic int unsigned eff_width();
        return (frame_width_q > MAX_W) ? MAX_W : frame_width_q;
    endfunction

    function automatic int unsigned eff_height();
        return (frame_height_q > MAX_H) ? MAX_H : frame_height_q;
    endfunction

    function automatic bit locate_pixel(input logic [COORD_W-1:0] x,
                                        input logic [COORD_W-1:0] y,
                                        output int unsigned addr);
        int unsigned w;
        int unsigned h;
        w = eff_width();
        h = eff_height();
        addr = y * w + x;
        return (x < w) && (y < h);
    endfunction

    function automatic logic [COLOR_W-1:0] blend_source_over(input logic [COLOR_W-1:0] src,
                                                             input logic [COLOR_W-1:0] dst);
        logic [COLOR_W-1:0] mixed;
        int unsigned        a;
        int unsigned        s;
        int unsigned        d;
        int unsigned        full;
        full = CH_MAX;
        a = src[31:24];
        for (int c = 0; c < 3; c++) begin
            s = src[8*c +: 8];
            d = dst[8*c +: 8];
            mixed[8*c +: 8] = 8'((s * a + d * (full - a)) / full);
        end
        mixed[31:24] = ALPHA_OPAQUE;
        return mixed;
    endfunction

    function automatic pixel_result_t apply_pixel_op(input logic [1:0] op,
                                                     input logic [COORD_W-1:0] x,
                                                     input logic [COORD_W-1:0] y,
                                                     input logic [COLOR_W-1:0] color);
        pixel_result_t res;
        int unsigned   addr;
        res.read_color = '0;
        res.in_bounds  = locate_pixel(x, y, addr);
        if (res.in_bounds) begin
            case (op)
                OP_WRITE: begin
                    shadow_pixels[addr]  = color;
                    shadow_written[addr] = 1'b1;
                end
                OP_READ: begin
                    res.read_color = shadow_pixels[addr];
                end
                OP_BLEND: begin
                    shadow_pixels[addr] = blend_source_over(color, shadow_pixels[addr]);
                end
                default: begin
                end
            endcase
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [COLOR_W-1:0] got,
                                   input logic [COLOR_W-1:0] want);
        $display("%0t ns: %s mismatch, got %h expected %h", $time, what, got, want);
        error_count++;
    endtask

    // A read or blend of a pixel that was never written is turned into a write.
    task automatic send_request(input logic [1:0] op, input logic [COORD_W-1:0] x,
                                input logic [COORD_W-1:0] y, input logic [COLOR_W-1:0] color);
        int unsigned addr;
        logic [1:0]  legal_op;
        legal_op = op;
        if ((op == OP_READ || op == OP_BLEND) && locate_pixel(x, y, addr)
            && !shadow_written[addr]) begin
            legal_op = OP_WRITE;
        end
        @(negedge aclk);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_op          <= legal_op;
        s_pixel_x     <= x;
        s_pixel_y     <= y;
        s_pixel_color <= color;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_pixel_results.push_back(apply_pixel_op(legal_op, x, y, color));
        last_x = x;
        last_y = y;
    endtask

    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_pixel_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_frame_reg(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_W-1:0] value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            REG_FRAME_WIDTH:  frame_width_q = value;
            REG_FRAME_HEIGHT: frame_height_q = value;
            default: begin
            end
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_frame_shape(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        settle();
        write_frame_reg(REG_FRAME_WIDTH, w);
        write_frame_reg(REG_FRAME_HEIGHT, h);
    endtask

    task automatic pick_coord(output logic [COORD_W-1:0] x, output logic [COORD_W-1:0] y);
        int unsigned w;
        int unsigned h;
        int          r;
        w = eff_width();
        h = eff_height();
        r = $urandom_range(99);
        if (w == 0 || h == 0 || r < 5) begin
            x = COORD_W'($urandom);
            y = COORD_W'($urandom);
        end else if (r < 12) begin
            x = COORD_W'(w + $urandom_range(2));
            y = COORD_W'($urandom_range(h - 1));
        end else if (r < 18) begin
            x = COORD_W'($urandom_range(w - 1));
            y = COORD_W'(h + $urandom_range(2));
        end else begin
            x = COORD_W'($urandom_range(w - 1));
            y = COORD_W'($urandom_range(h - 1));
        end
    endtask

    function automatic logic [COLOR_W-1:0] random_color();
        logic [COLOR_W-1:0] c;
        int                 r;
        c = $urandom;
        r = $urandom_range(99);
        if (r < 10) c[31:24] = 8'h00;
        else if (r < 20) c[31:24] = ALPHA_OPAQUE;
        return c;
    endfunction

    task automatic send_random_item();
        logic [1:0]         op;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        int                 r;
        r = $urandom_range(99);
        if (r < 8) begin
            op = 2'($urandom);
            x  = COORD_W'($urandom);
            y  = COORD_W'($urandom);
        end else begin
            r  = $urandom_range(99);
            op = (r < 30) ? OP_WRITE : (r < 60) ? OP_READ : (r < 95) ? OP_BLEND : OP_UNUSED;
            if ($urandom_range(99) < 15) begin
                x = last_x;
                y = last_y;
            end else begin
                pick_coord(x, y);
            end
        end
        send_request(op, x, y, random_color());
    endtask

    // Paints are blend runs over a rectangle, crops are read runs over one.
    task automatic run_traffic_segment(input int items);
        logic [COORD_W-1:0] ox;
        logic [COORD_W-1:0] oy;
        logic [1:0]         rect_op;
        int                 sent;
        int                 r;
        int                 pw;
        int                 ph;
        sent = 0;
        while (sent < items) begin
            r = $urandom_range(99);
            if (r < 45) begin
                rect_op = (r < 25) ? OP_BLEND : OP_READ;
                pick_coord(ox, oy);
                pw = $urandom_range(4, 1);
                ph = $urandom_range(4, 1);
                for (int j = 0; j < ph; j++) begin
                    for (int i = 0; i < pw; i++) begin
                        send_request(rect_op, COORD_W'(ox + i), COORD_W'(oy + j),
                                     random_color());
                        sent++;
                    end
                end
            end else if (r < 55) begin
                pick_coord(ox, oy);
                repeat ($urandom_range(4, 2)) begin
                    send_request(OP_BLEND, ox, oy, random_color());
                    sent++;
                end
                send_request(OP_READ, ox, oy, random_color());
                sent++;
            end else begin
                send_random_item();
                sent++;
            end
        end
    endtask

    task automatic test_directed_extremes();
        set_frame_shape(DIM_RESET, DIM_RESET);
        send_request(OP_WRITE, 0, 0, 32'hFFFF_FFFF);
        send_request(OP_WRITE, 255, 255, 32'h0000_0000);
        send_request(OP_READ, 0, 0, 32'h0);
        send_request(OP_READ, 255, 255, 32'hFFFF_FFFF);
        send_request(OP_WRITE, 255, 0, 32'h80FF_0001);
        send_request(OP_BLEND, 255, 0, 32'h0012_3456);
        send_request(OP_BLEND, 255, 0, 32'hFFA5_C3E7);
        send_request(OP_BLEND, 255, 0, 32'h80FF_FFFF);
        send_request(OP_READ, 255, 0, 32'h0);
        send_request(OP_WRITE, 0, 255, 32'h7F7F_7F7F);
        send_request(OP_BLEND, 0, 255, 32'h0100_0000);
        send_request(OP_READ, 0, 255, 32'h0);
        send_request(OP_WRITE, 256, 0, 32'h1234_5678);
        send_request(OP_READ, 0, 256, 32'h0);
        send_request(OP_BLEND, 4095, 4095, 32'hFFFF_FFFF);
        send_request(OP_READ, 4095, 0, 32'h0);
        send_request(OP_UNUSED, 0, 0, 32'hDEAD_BEEF);
        send_request(OP_UNUSED, 300, 300, 32'hDEAD_BEEF);
        send_request(OP_READ, 0, 0, 32'h0);
        send_request(OP_WRITE, 128, 64, 32'hAAAA_AAAA);
        send_request(OP_READ, 128, 64, 32'h0);
        send_request(OP_BLEND, 0, 0, 32'h5555_5555);
        send_request(OP_READ, 0, 0, 32'h0);
    endtask

    task automatic test_frame_registers();
        set_frame_shape(0, DIM_RESET);
        send_request(OP_READ, 0, 0, 32'h0);
        send_request(OP_WRITE, 0, 0, 32'h0102_0304);
        set_frame_shape(DIM_RESET, 0);
        send_request(OP_BLEND, 0, 0, 32'hFFFF_FFFF);
        set_frame_shape(9'd511, 9'd511);
        send_request(OP_READ, 255, 255, 32'h0);
        send_request(OP_WRITE, 256, 256, 32'h0BAD_F00D);
        send_request(OP_READ, 255, 0, 32'h0);
        set_frame_shape(9'd300, 9'd257);
        send_request(OP_READ, 0, 0, 32'h0);
        set_frame_shape(1, DIM_RESET);
        send_request(OP_READ, 0, 0, 32'h0);
        send_request(OP_READ, 0, 255, 32'h0);
        send_request(OP_WRITE, 0, 1, 32'hC0FF_EE00);
        send_request(OP_READ, 1, 0, 32'h0);
        set_frame_shape(2, 1);
        send_request(OP_READ, 1, 0, 32'h0);
        send_request(OP_READ, 0, 1, 32'h0);
        set_frame_shape(1, 1);
        send_request(OP_WRITE, 0, 0, 32'h00C0_FFEE);
        send_request(OP_READ, 0, 0, 32'h0);
        send_request(OP_READ, 1, 0, 32'h0);
    endtask

    task automatic test_random_traffic(input int segments, input int items_per_segment);
        int r;
        for (int seg = 0; seg < segments; seg++) begin
            r = $urandom_range(9);
            case (r)
                0: set_frame_shape(DIM_RESET, DIM_RESET);
                1: set_frame_shape(CFG_W'($urandom_range(511, 257)),
                                   CFG_W'($urandom_range(8, 1)));
                2: set_frame_shape(0, CFG_W'($urandom));
                3: set_frame_shape(CFG_W'($urandom_range(8, 1)), 0);
                4: set_frame_shape(CFG_W'($urandom_range(16, 1)),
                                   CFG_W'($urandom_range(511, 257)));
                default: set_frame_shape(CFG_W'($urandom_range(16, 1)),
                                         CFG_W'($urandom_range(16, 1)));
            endcase
            run_traffic_segment(items_per_segment);
        end
    endtask

    task automatic test_receiver_hold_off();
        set_frame_shape(16, 16);
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        hold_off_len      = 400;
        hold_off_serial++;
        repeat (60) send_random_item();
    endtask

    always @(negedge aclk) begin
        if (hold_off_serial != hold_off_taken) begin
            hold_off_taken = hold_off_serial;
            hold_off_left  = hold_off_len;
        end
        if (hold_off_left > 0) begin
            hold_off_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_pixel_results.size() == 0) begin
                report_mismatch("unrequested result", m_read_color, '0);
            end else begin
                oldest_result = pending_pixel_results.pop_front();
                if (m_read_color !== oldest_result.read_color) begin
                    report_mismatch("read_color", m_read_color, oldest_result.read_color);
                end
                if (m_in_bounds !== oldest_result.in_bounds) begin
                    report_mismatch("in_bounds", m_in_bounds, oldest_result.in_bounds);
                end
            end
        end
    end

    initial begin
        aresetn        = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_wdata      = '0;
        s_valid        = 1'b0;
        s_op           = OP_WRITE;
        s_pixel_x      = '0;
        s_pixel_y      = '0;
        s_pixel_color  = '0;
        frame_width_q  = DIM_RESET;
        frame_height_q = DIM_RESET;
        for (int i = 0; i < STORE_WORDS; i++) begin
            shadow_pixels[i]  = '0;
            shadow_written[i] = 1'b0;
        end
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        sender_idle_pct   = 11;
        receiver_idle_pct = 56;
        test_directed_extremes();
        test_frame_registers();
        test_random_traffic(8, 65);
        sender_idle_pct   = 56;
        receiver_idle_pct = 11;
        test_random_traffic(8, 65);
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        test_random_traffic(8, 65);
        test_receiver_hold_off();
        settle();

        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
